>>> rtl/core/csp_pkg.sv
package csp_pkg;

  localparam int WORD_W      = 32;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command codes
  localparam logic [CMD_W-1:0] CMD_BEGIN   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_END     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SETTING = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SERVICE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CONSUME = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_STARTED    = 4'd0;
  localparam logic [STATUS_W-1:0] STAT_ENDED      = 4'd1;
  localparam logic [STATUS_W-1:0] STAT_BOUNDARY   = 4'd2;
  localparam logic [STATUS_W-1:0] STAT_INVALID    = 4'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_SB     = 4'd4;
  localparam logic [STATUS_W-1:0] STAT_INTERV     = 4'd5;
  localparam logic [STATUS_W-1:0] STAT_UNEXPECTED = 4'd6;
  localparam logic [STATUS_W-1:0] STAT_BAD_VER    = 4'd7;
  localparam logic [STATUS_W-1:0] STAT_ACCEPTED   = 4'd8;
  localparam logic [STATUS_W-1:0] STAT_SUM_BAD    = 4'd9;
  localparam logic [STATUS_W-1:0] STAT_COMMIT_BAD = 4'd10;
  localparam logic [STATUS_W-1:0] STAT_COMMITTED  = 4'd11;
  localparam logic [STATUS_W-1:0] STAT_MATCHED    = 4'd12;
  localparam logic [STATUS_W-1:0] STAT_MISSING    = 4'd13;

  // configuration register indexes
  localparam logic [0:0] REG_VERSION = 1'b0;
  localparam logic [0:0] REG_BASE    = 1'b1;

  localparam logic [WORD_W-1:0] VERSION_RESET = 32'd1;
  localparam logic [WORD_W-1:0] BASE_RESET    = 32'd0;

  localparam logic [WORD_W-1:0] FNV_OFFSET    = 32'd2166136261;
  localparam logic [WORD_W-1:0] FNV_PRIME     = 32'd16777619;
  localparam logic [WORD_W-1:0] CHECK_DOMAIN  = 32'h4355_5231;
  localparam logic [WORD_W-1:0] COMMIT_DOMAIN = 32'h5343_4631;
  localparam logic [7:0]        BYTE_MASK     = 8'hff;

  function automatic logic [WORD_W-1:0] fnv_word(input logic [WORD_W-1:0] h,
                                                  input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] rest;
    acc  = h;
    rest = w;
    for (int k = 0; k < 4; k++) begin
      acc  = WORD_W'((acc ^ {24'b0, rest[7:0] & BYTE_MASK}) * FNV_PRIME);
      rest = rest >> 8;
    end
    return acc;
  endfunction

  // hash state after the fixed domain word; the rest is hashed at run time
  localparam logic [WORD_W-1:0] FNV_PREFIX = fnv_word(FNV_OFFSET, CHECK_DOMAIN);

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] setting_index;
    logic signed [WORD_W-1:0] setting_value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   frame_epoch;
    logic [WORD_W-1:0]   frame_sequence;
    logic [WORD_W-1:0]   frame_checksum;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              foreign;
    logic [2:0]        offset;
    logic [WORD_W-1:0] value;
  } cls_item_t;

  typedef struct packed {
    logic      empty;
    cls_item_t head;
  } q_status_t;

endpackage

>>> rtl/core/csp_front.sv
module csp_front (
  input  logic                       push,
  output logic                       full,
  input  csp_pkg::in_item_t          in_data,
  input  logic [csp_pkg::WORD_W-1:0] base_index,
  input  logic                       q_full,
  output logic                       q_wr,
  output csp_pkg::cls_item_t         q_wdata
);
  import csp_pkg::*;

  logic signed [WORD_W:0] offset;

  // offset is exact over the whole signed range
  assign offset = {in_data.setting_index[WORD_W-1], in_data.setting_index}
                - {base_index[WORD_W-1], base_index};

  assign full = q_full;
  assign q_wr = push && !q_full;

  always_comb begin
    q_wdata.cmd     = in_data.cmd;
    q_wdata.offset  = offset[2:0];
    q_wdata.value   = in_data.setting_value;
    q_wdata.foreign = offset[WORD_W] || (offset[WORD_W-1:3] != '0) || (offset[2:0] > 3'd4);
  end

endmodule

>>> rtl/core/csp_queue.sv
module csp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr,
  input  csp_pkg::cls_item_t wdata,
  output logic               full,
  input  logic               rd,
  output csp_pkg::q_status_t q_stat
);
  import csp_pkg::*;

  cls_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_wr, do_rd;

  assign full         = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign q_stat.head  = mem_r[rd_ptr_r];
  assign do_wr        = wr && !full;
  assign do_rd        = rd && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/core/csp_back.sv
module csp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [csp_pkg::WORD_W-1:0] version,
  input  csp_pkg::q_status_t         q_stat,
  output logic                       q_pop,
  output logic                       empty,
  input  logic                       pop,
  output csp_pkg::out_item_t         out_data
);
  import csp_pkg::*;

  typedef enum logic [1:0] {BK_READY, BK_HASH, BK_CHECK} bk_state_t;
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_EPOCH    = 3'd1,
    PH_SEQUENCE = 3'd2,
    PH_CHECKSUM = 3'd3,
    PH_COMMIT   = 3'd4,
    PH_FRAME    = 3'd5,
    PH_POISONED = 3'd6
  } phase_t;

  bk_state_t         state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic              in_packet_r, in_packet_nxt;
  logic [WORD_W-1:0] pend_epoch_r, pend_epoch_nxt;
  logic [WORD_W-1:0] pend_seq_r, pend_seq_nxt;
  logic [WORD_W-1:0] pend_sum_r, pend_sum_nxt;
  logic [WORD_W-1:0] hash_r, hash_nxt;
  logic [WORD_W-1:0] chk_word_r, chk_word_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              out_free;
  logic [WORD_W-1:0] hash_word;
  logic [7:0]        hash_byte;
  logic [WORD_W-1:0] hash_step;
  logic [WORD_W-1:0] commit_word;
  cls_item_t         it;

  assign it       = q_stat.head;
  assign out_free = !out_valid_r || pop;
  assign empty    = !out_valid_r;
  assign out_data = out_data_r;
  assign q_pop    = (state_r == BK_READY) && !q_stat.empty && out_free;

  // 12 byte steps: version, epoch, sequence, low byte first
  always_comb begin
    case (cnt_r[3:2])
      2'd0:    hash_word = version;
      2'd1:    hash_word = pend_epoch_r;
      default: hash_word = pend_seq_r;
    endcase
  end
  assign hash_byte = hash_word[{cnt_r[1:0], 3'b000} +: 8];
  assign hash_step = WORD_W'((hash_r ^ {24'b0, hash_byte}) * FNV_PRIME);

  assign commit_word = COMMIT_DOMAIN
                     ^ {pend_sum_r[20:0], pend_sum_r[31:21]}
                     ^ {pend_epoch_r[28:0], pend_epoch_r[31:29]}
                     ^ {pend_seq_r[12:0], pend_seq_r[31:13]};

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    in_packet_nxt  = in_packet_r;
    pend_epoch_nxt = pend_epoch_r;
    pend_seq_nxt   = pend_seq_r;
    pend_sum_nxt   = pend_sum_r;
    hash_nxt       = hash_r;
    chk_word_nxt   = chk_word_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !pop;
    out_data_nxt   = out_data_r;

    case (state_r)
      BK_READY: begin
        if (q_pop) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          case (it.cmd)
            CMD_BEGIN: begin
              out_data_nxt.status = in_packet_r ? STAT_BOUNDARY : STAT_STARTED;
              phase_nxt     = PH_IDLE;
              in_packet_nxt = 1'b1;
            end
            CMD_END, CMD_SETTING, CMD_SERVICE, CMD_CONSUME: begin
              if (!in_packet_r) begin
                out_data_nxt.status = STAT_INVALID;
              end else if (it.cmd == CMD_END) begin
                out_data_nxt.status = (phase_r != PH_IDLE) ? STAT_BOUNDARY : STAT_ENDED;
                phase_nxt     = PH_IDLE;
                in_packet_nxt = 1'b0;
              end else if (it.cmd == CMD_SERVICE) begin
                if (phase_r == PH_IDLE) begin
                  out_data_nxt.status = STAT_NOT_SB;
                end else begin
                  out_data_nxt.status = STAT_INTERV;
                  phase_nxt = PH_POISONED;
                end
              end else if (it.cmd == CMD_CONSUME) begin
                if (phase_r != PH_FRAME) begin
                  out_data_nxt.status = STAT_MISSING;
                  phase_nxt = PH_POISONED;
                end else begin
                  out_data_nxt.status         = STAT_MATCHED;
                  out_data_nxt.frame_epoch    = pend_epoch_r;
                  out_data_nxt.frame_sequence = pend_seq_r;
                  out_data_nxt.frame_checksum = pend_sum_r;
                  phase_nxt = PH_IDLE;
                end
              end else if (it.foreign) begin
                if (phase_r != PH_IDLE) begin
                  out_data_nxt.status = STAT_INTERV;
                  phase_nxt = PH_POISONED;
                end else begin
                  out_data_nxt.status = STAT_NOT_SB;
                end
              end else if (phase_r == PH_POISONED) begin
                out_data_nxt.status = STAT_UNEXPECTED;
              end else if (it.offset == 3'd0) begin
                if (phase_r != PH_IDLE) begin
                  out_data_nxt.status = STAT_UNEXPECTED;
                  phase_nxt = PH_POISONED;
                end else if (it.value != version) begin
                  out_data_nxt.status = STAT_BAD_VER;
                  phase_nxt = PH_POISONED;
                end else begin
                  out_data_nxt.status = STAT_ACCEPTED;
                  phase_nxt = PH_EPOCH;
                end
              end else if (phase_r == PH_IDLE || phase_r == PH_FRAME
                           || it.offset != 3'(phase_r)) begin
                out_data_nxt.status = STAT_UNEXPECTED;
                phase_nxt = PH_POISONED;
              end else if (phase_r == PH_EPOCH) begin
                out_data_nxt.status = STAT_ACCEPTED;
                pend_epoch_nxt = it.value;
                phase_nxt      = PH_SEQUENCE;
              end else if (phase_r == PH_SEQUENCE) begin
                if (pend_epoch_r == '0 && it.value != '0) begin
                  out_data_nxt.status = STAT_UNEXPECTED;
                  phase_nxt = PH_POISONED;
                end else begin
                  out_data_nxt.status = STAT_ACCEPTED;
                  pend_seq_nxt = it.value;
                  phase_nxt    = PH_CHECKSUM;
                end
              end else if (phase_r == PH_CHECKSUM) begin
                // result is held back until the header hash is done
                out_valid_nxt = out_valid_r && !pop;
                out_data_nxt  = out_data_r;
                chk_word_nxt  = it.value;
                hash_nxt      = FNV_PREFIX;
                cnt_nxt       = '0;
                state_nxt     = BK_HASH;
              end else if (it.value != commit_word) begin
                out_data_nxt.status = STAT_COMMIT_BAD;
                phase_nxt = PH_POISONED;
              end else begin
                out_data_nxt.status = STAT_COMMITTED;
                phase_nxt = PH_FRAME;
              end
            end
            default: begin
              out_data_nxt.status = STAT_INVALID;
            end
          endcase
        end
      end
      BK_HASH: begin
        hash_nxt = hash_step;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 4'd11) begin
          state_nxt = BK_CHECK;
        end
      end
      BK_CHECK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = BK_READY;
          if (chk_word_r != hash_r) begin
            out_data_nxt.status = STAT_SUM_BAD;
            phase_nxt = PH_POISONED;
          end else begin
            out_data_nxt.status = STAT_ACCEPTED;
            pend_sum_nxt = chk_word_r;
            phase_nxt    = PH_COMMIT;
          end
        end
      end
      default: begin
        state_nxt = BK_READY;
      end
    endcase

    // idle and poisoned both drop the pending tuple
    if (phase_nxt == PH_IDLE || phase_nxt == PH_POISONED) begin
      pend_epoch_nxt = '0;
      pend_seq_nxt   = '0;
      pend_sum_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_READY;
      phase_r      <= PH_IDLE;
      in_packet_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_epoch_r <= '0;
      pend_seq_r   <= '0;
      pend_sum_r   <= '0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      in_packet_r  <= in_packet_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_epoch_r <= pend_epoch_nxt;
      pend_seq_r   <= pend_seq_nxt;
      pend_sum_r   <= pend_sum_nxt;
      cnt_r        <= cnt_nxt;
    end
    hash_r     <= hash_nxt;
    chk_word_r <= chk_word_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_READY) |-> !q_pop)
    else $error("queue popped while hashing");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_HASH) |-> (cnt_r <= 4'd11))
    else $error("hash step count out of range");

  a_hash_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_HASH && cnt_r == 4'd11) |=> (state_r == BK_CHECK))
    else $error("hash did not finish into check");

  a_phase_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> in_packet_r)
    else $error("sideband phase active outside a packet");

  a_tuple_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != STAT_MATCHED) |->
      (out_data_r.frame_epoch == '0 && out_data_r.frame_sequence == '0
       && out_data_r.frame_checksum == '0))
    else $error("tuple fields set on a non-matched result");
`endif

endmodule

>>> rtl/core/cursor_sideband_parser.sv
// Channel   Handshake            Payload               Accepted when
// input     push / full          in_data               push && !full
// result    empty / pop          out_data              pop && !empty
// config    cfg_we               cfg_index, cfg_wdata  cfg_we
//
// A checksum setting holds the back end while its header hash runs, one FNV
// byte step per cycle through one 32x32 constant multiplier over 12 bytes,
// between issue and compare; other transactions are resolved as they are
// popped. Each result is registered before it reaches the ports. A 2-entry
// queue decouples the classifier from the back end; full rises only when
// both entries hold transactions. The result register frees while pop is
// high. Reset is synchronous, active low; config registers return to their reset values.
module cursor_sideband_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  csp_pkg::in_item_t          in_data,
  output logic                       empty,
  input  logic                       pop,
  output csp_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [csp_pkg::WORD_W-1:0] cfg_wdata
);
  import csp_pkg::*;

  logic [WORD_W-1:0] version_r;
  logic [WORD_W-1:0] base_r;
  logic              q_full;
  logic              q_wr;
  logic              q_pop;
  cls_item_t         q_wdata;
  q_status_t         q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= VERSION_RESET;
      base_r    <= BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VERSION: version_r <= cfg_wdata;
        REG_BASE:    base_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  csp_front u_front (
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .base_index (base_r),
    .q_full     (q_full),
    .q_wr       (q_wr),
    .q_wdata    (q_wdata)
  );

  csp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wdata  (q_wdata),
    .full   (q_full),
    .rd     (q_pop),
    .q_stat (q_stat)
  );

  csp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .version  (version_r),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import csp_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 350;
  localparam int SETTLE       = 30;
  localparam int IDLE_PERCENT = 18;
  localparam int PRINT_CAP    = 30;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EPOCH, ST_SEQUENCE, ST_CHECKSUM, ST_COMMIT, ST_FRAME, ST_POISONED
  } parse_phase_t;

  typedef enum int {
    FL_NONE, FL_VERSION, FL_SUM, FL_COMMIT, FL_ORDER, FL_FOREIGN,
    FL_SERVICE, FL_CONSUME, FL_CUT, FL_EPOCH0
  } flaw_t;

  class sideband_scoreboard;
    logic [WORD_W-1:0] version;
    logic [WORD_W-1:0] base;
    parse_phase_t      phase;
    bit                in_packet;
    logic [WORD_W-1:0] p_epoch;
    logic [WORD_W-1:0] p_seq;
    logic [WORD_W-1:0] p_sum;
    out_item_t         awaited[$];
    int                mismatches;

    function new();
      version    = VERSION_RESET;
      base       = BASE_RESET;
      in_packet  = 1'b0;
      mismatches = 0;
      clear_to(ST_IDLE);
    endfunction

    static function logic [WORD_W-1:0] fold_word(logic [WORD_W-1:0] h,
                                                 logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] acc;
      acc = h;
      for (int k = 0; k < 4; k++) begin
        acc = acc ^ {24'd0, w[8*k +: 8]};
        acc = acc * FNV_PRIME;
      end
      return acc;
    endfunction

    static function logic [WORD_W-1:0] header_sum(logic [WORD_W-1:0] ver,
                                                  logic [WORD_W-1:0] e,
                                                  logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] h;
      h = fold_word(FNV_OFFSET, CHECK_DOMAIN);
      h = fold_word(h, ver);
      h = fold_word(h, e);
      return fold_word(h, s);
    endfunction

    static function logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] v, int s);
      return (v << s) | (v >> (WORD_W - s));
    endfunction

    static function logic [WORD_W-1:0] commit_word(logic [WORD_W-1:0] chk,
                                                   logic [WORD_W-1:0] e,
                                                   logic [WORD_W-1:0] s);
      return COMMIT_DOMAIN ^ rotl(chk, 11) ^ rotl(e, 3) ^ rotl(s, 19);
    endfunction

    function void clear_to(parse_phase_t ph);
      p_epoch = '0;
      p_seq   = '0;
      p_sum   = '0;
      phase   = ph;
    endfunction

    function void write_reg(logic [0:0] idx, logic [WORD_W-1:0] v);
      if (idx == REG_VERSION) version = v;
      else base = v;
    endfunction

    function logic [STATUS_W-1:0] observe(logic [WORD_W-1:0] idx, logic [WORD_W-1:0] word);
      longint off;
      off = longint'($signed(idx)) - longint'($signed(base));
      if (off < 0 || off > 4) begin
        if (phase != ST_IDLE) begin
          clear_to(ST_POISONED);
          return STAT_INTERV;
        end
        return STAT_NOT_SB;
      end
      if (phase == ST_POISONED) return STAT_UNEXPECTED;
      if (off == 0) begin
        if (phase != ST_IDLE) begin
          clear_to(ST_POISONED);
          return STAT_UNEXPECTED;
        end
        if (word != version) begin
          clear_to(ST_POISONED);
          return STAT_BAD_VER;
        end
        phase = ST_EPOCH;
        return STAT_ACCEPTED;
      end
      if (phase < ST_EPOCH || phase > ST_COMMIT || off != longint'(int'(phase))) begin
        clear_to(ST_POISONED);
        return STAT_UNEXPECTED;
      end
      case (phase)
        ST_EPOCH: begin
          p_epoch = word;
          phase   = ST_SEQUENCE;
          return STAT_ACCEPTED;
        end
        ST_SEQUENCE: begin
          p_seq = word;
          // epoch zero only admits sequence zero
          if (p_epoch == '0 && word != '0) begin
            clear_to(ST_POISONED);
            return STAT_UNEXPECTED;
          end
          phase = ST_CHECKSUM;
          return STAT_ACCEPTED;
        end
        ST_CHECKSUM: begin
          if (word != header_sum(version, p_epoch, p_seq)) begin
            clear_to(ST_POISONED);
            return STAT_SUM_BAD;
          end
          p_sum = word;
          phase = ST_COMMIT;
          return STAT_ACCEPTED;
        end
        default: begin
          if (word != commit_word(p_sum, p_epoch, p_seq)) begin
            clear_to(ST_POISONED);
            return STAT_COMMIT_BAD;
          end
          phase = ST_FRAME;
          return STAT_COMMITTED;
        end
      endcase
    endfunction

    function out_item_t parse_step(in_item_t it);
      out_item_t r;
      r = '0;
      if (it.cmd == CMD_BEGIN) begin
        r.status  = in_packet ? STAT_BOUNDARY : STAT_STARTED;
        clear_to(ST_IDLE);
        in_packet = 1'b1;
      end else if (it.cmd > CMD_CONSUME || !in_packet) begin
        r.status = STAT_INVALID;
      end else if (it.cmd == CMD_END) begin
        r.status  = (phase != ST_IDLE) ? STAT_BOUNDARY : STAT_ENDED;
        clear_to(ST_IDLE);
        in_packet = 1'b0;
      end else if (it.cmd == CMD_SETTING) begin
        r.status = observe(it.setting_index, it.setting_value);
      end else if (it.cmd == CMD_SERVICE) begin
        if (phase == ST_IDLE) begin
          r.status = STAT_NOT_SB;
        end else begin
          clear_to(ST_POISONED);
          r.status = STAT_INTERV;
        end
      end else begin
        if (phase != ST_FRAME) begin
          clear_to(ST_POISONED);
          r.status = STAT_MISSING;
        end else begin
          r.frame_epoch    = p_epoch;
          r.frame_sequence = p_seq;
          r.frame_checksum = p_sum;
          clear_to(ST_IDLE);
          r.status = STAT_MATCHED;
        end
      end
      return r;
    endfunction

    function void note_accepted(in_item_t it);
      awaited.push_back(parse_step(it));
    endfunction

    task report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("mismatch %0s: got %h want %h", what, got, want);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        report("unexpected result", {28'd0, got.status}, '0);
      end else begin
        want = awaited.pop_front();
        if (got.status !== want.status)
          report("status", {28'd0, got.status}, {28'd0, want.status});
        if (got.frame_epoch !== want.frame_epoch)
          report("frame_epoch", got.frame_epoch, want.frame_epoch);
        if (got.frame_sequence !== want.frame_sequence)
          report("frame_sequence", got.frame_sequence, want.frame_sequence);
        if (got.frame_checksum !== want.frame_checksum)
          report("frame_checksum", got.frame_checksum, want.frame_checksum);
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  in_item_t           in_data;
  logic               empty;
  logic               pop;
  out_item_t          out_data;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [WORD_W-1:0]  cfg_wdata;

  sideband_scoreboard sb;
  logic [WORD_W-1:0]  cur_version;
  logic [WORD_W-1:0]  cur_base;
  int                 sent;
  bit                 steady;
  bit                 hold_req;

  cursor_sideband_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // sample every handshake on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (push && !full) sb.note_accepted(in_data);
      if (pop && !empty) sb.check_result(out_data);
    end
  end

  // result side: random pop, plus one long hold-off on request
  initial begin
    int pause;
    pause = 0;
    pop   = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pause    = HOLD_CYCLES;
      end
      if (pause > 0) begin
        pop <= 1'b0;
        pause--;
      end else begin
        pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  function automatic in_item_t make_item(logic [CMD_W-1:0] c, logic [WORD_W-1:0] i,
                                         logic [WORD_W-1:0] v);
    in_item_t it;
    it.cmd           = c;
    it.setting_index = i;
    it.setting_value = v;
    return it;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] foreign_index();
    case ($urandom_range(3))
      0:       return cur_base - 32'd1;
      1:       return cur_base + 32'd5;
      2:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // entered and left at a falling edge; one transaction per call
  task automatic send_item(in_item_t it);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < IDLE_PERCENT) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full !== 1'b0);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_cmd(logic [CMD_W-1:0] c, logic [WORD_W-1:0] i, logic [WORD_W-1:0] v);
    send_item(make_item(c, i, v));
  endtask

  task automatic send_noise();
    logic [WORD_W-1:0] idx;
    case ($urandom_range(3))
      0, 1:    idx = cur_base + $urandom_range(4);
      2:       idx = foreign_index();
      default: idx = $urandom;
    endcase
    send_cmd(CMD_W'($urandom_range(7)), idx, $urandom_range(1) ? $urandom : cur_version);
  endtask

  // version, epoch, sequence, checksum, commit, consume; optionally spoiled
  task automatic send_sideband(flaw_t flaw, logic [WORD_W-1:0] e, logic [WORD_W-1:0] s);
    in_item_t          steps [6];
    int                at;
    logic [WORD_W-1:0] chk;
    logic [WORD_W-1:0] cm;
    logic [WORD_W-1:0] flip;
    if (flaw == FL_EPOCH0) begin
      e = '0;
      s = s | 32'd1;
    end else if (e == '0) begin
      s = '0;
    end
    chk  = sideband_scoreboard::header_sum(cur_version, e, s);
    cm   = sideband_scoreboard::commit_word(chk, e, s);
    flip = 32'd1 << $urandom_range(31);
    steps[0] = make_item(CMD_SETTING, cur_base,
                         (flaw == FL_VERSION) ? cur_version ^ flip : cur_version);
    steps[1] = make_item(CMD_SETTING, cur_base + 32'd1, e);
    steps[2] = make_item(CMD_SETTING, cur_base + 32'd2, s);
    steps[3] = make_item(CMD_SETTING, cur_base + 32'd3, (flaw == FL_SUM) ? chk ^ flip : chk);
    steps[4] = make_item(CMD_SETTING, cur_base + 32'd4, (flaw == FL_COMMIT) ? cm ^ flip : cm);
    steps[5] = make_item(CMD_CONSUME, $urandom, $urandom);
    at = $urandom_range(1, 4);
    if (flaw == FL_ORDER)
      steps[at].setting_index = cur_base + ((at + $urandom_range(1, 4)) % 5);
    for (int k = 0; k < 6; k++) begin
      if (k == at) begin
        if (flaw == FL_CUT) break;
        case (flaw)
          FL_FOREIGN: send_cmd(CMD_SETTING, foreign_index(), $urandom);
          FL_SERVICE: send_cmd(CMD_SERVICE, $urandom, $urandom);
          FL_CONSUME: send_cmd(CMD_CONSUME, $urandom, $urandom);
          default: ;
        endcase
      end
      send_item(steps[k]);
    end
  endtask

  task automatic send_packet();
    flaw_t flaw;
    int    n;
    if ($urandom_range(9) != 0) send_cmd(CMD_BEGIN, $urandom, $urandom);
    n = $urandom_range(1, 3);
    repeat (n) begin
      if ($urandom_range(3) == 0) send_noise();
      flaw = ($urandom_range(99) < 60) ? FL_NONE : flaw_t'($urandom_range(FL_VERSION, FL_EPOCH0));
      send_sideband(flaw, pick_word(), pick_word());
      if (flaw != FL_NONE && $urandom_range(1)) send_cmd(CMD_BEGIN, $urandom, $urandom);
    end
    if ($urandom_range(4) != 0) send_cmd(CMD_END, $urandom, $urandom);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic program_regs(logic [WORD_W-1:0] ver, logic [WORD_W-1:0] b);
    cfg_we    <= 1'b1;
    cfg_index <= REG_VERSION;
    cfg_wdata <= ver;
    @(negedge clk);
    cfg_index <= REG_BASE;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_version = ver;
    cur_base    = b;
  endtask

  task automatic run_phase(int quota, bit with_hold);
    int start;
    start = sent;
    while (sent - start < quota) begin
      if (with_hold && sent - start >= 100) begin
        hold_req  = 1'b1;
        with_hold = 1'b0;
      end
      if ($urandom_range(99) < 75) send_packet();
      else send_noise();
    end
  endtask

  task automatic run_directed();
    send_cmd(CMD_END, 0, 0);
    send_cmd(CMD_SETTING, 0, 1);
    send_cmd(3'd7, '1, '1);
    send_cmd(CMD_BEGIN, 0, 0);
    send_sideband(FL_NONE, '1, '1);
    send_cmd(CMD_CONSUME, 0, 0);            // frame without header
    send_cmd(CMD_BEGIN, 0, 0);              // begin inside a packet
    send_cmd(CMD_SETTING, 2, 5);            // sequence while idle
    send_cmd(CMD_SETTING, 0, 1);            // sideband while poisoned
    send_cmd(CMD_SERVICE, 0, 0);
    send_cmd(CMD_END, 0, 0);                // end while poisoned
    send_cmd(CMD_BEGIN, 0, 0);
    send_cmd(CMD_SETTING, 32'h8000_0000, 0);
    send_cmd(CMD_SERVICE, 0, 0);
    send_cmd(CMD_SETTING, 0, 0);            // wrong version
    send_cmd(CMD_SETTING, 32'h7fff_ffff, 0);
    send_cmd(CMD_BEGIN, 0, 0);
    send_cmd(CMD_SETTING, 0, 1);
    send_cmd(CMD_SETTING, 0, 1);            // version setting twice
    send_cmd(CMD_BEGIN, 0, 0);
    send_cmd(CMD_SETTING, 0, 1);
    send_cmd(CMD_SETTING, 1, 0);
    send_cmd(CMD_SETTING, 2, 1);            // epoch zero, sequence nonzero
    send_cmd(CMD_END, 0, 0);
  endtask

  initial begin
    logic [WORD_W-1:0] versions [5];
    logic [WORD_W-1:0] bases [5];
    sb          = new();
    rst_n       = 1'b0;
    push        = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    cur_version = VERSION_RESET;
    cur_base    = BASE_RESET;
    sent        = 0;
    steady      = 1'b0;
    hold_req    = 1'b0;

    versions[0] = VERSION_RESET;  bases[0] = BASE_RESET;
    versions[1] = '0;             bases[1] = 32'h8000_0000;
    versions[2] = '1;             bases[2] = 32'h7fff_fffb;
    versions[3] = $urandom;       bases[3] = $urandom;
    versions[4] = $urandom;       bases[4] = 32'hffff_fffd;
    if ($signed(bases[3]) > $signed(32'h7fff_fffb)) bases[3] = bases[3] - 32'd16;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain();

    for (int p = 0; p < 5; p++) begin
      program_regs(versions[p], bases[p]);
      steady = (p == 2);
      run_phase(PHASE_ITEMS, p == 0);
      steady = 1'b0;
      drain();
    end

    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/csp_pkg.sv
rtl/core/csp_front.sv
rtl/core/csp_queue.sv
rtl/core/csp_back.sv
rtl/core/cursor_sideband_parser.sv
bench/testbench.sv
